// ===== rtl/ir_pulse_width_capture_defines.svh =====
// Assertion macros shared by the infrared pulse capture RTL.
// Each macro assumes signals named clk and rst_n in the calling module.
`ifndef IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IRPW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IRPW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/irpw_pkg.sv =====
// Package for the infrared pulse width capture block.
// Holds sizes, mode and register codes, and the item and request structs.
package irpw_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RIDX_W   = 6;
  localparam int CMP_W    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int WIDTH_W  = 16;
  localparam int TIME_W   = 32;
  localparam int GLITCH_W = 16;
  localparam int TMO_W    = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_POLL  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_MIN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'd1;

  localparam logic [GLITCH_W-1:0] GLITCH_RESET  = 16'd250;
  localparam logic [TMO_W-1:0]    TIMEOUT_RESET = 20'd6000;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] time_us;
    logic [RIDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic               frame_ready;
    logic [6:0]         pulse_count;
    logic [WIDTH_W-1:0] entry_width;
  } out_item_t;

  // Memory request from the control unit for one accepted item.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [WIDTH_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  // Status of an accepted item after its state update.
  typedef struct packed {
    logic       frame_ready;
    logic [6:0] pulse_count;
    logic       hit;
  } stage_info_t;

endpackage

// ===== rtl/irpw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module irpw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/irpw_ctrl.sv =====
// Control unit: configuration registers, frame state and memory requests.
// Depends on irpw_pkg and the assertion macro header.
`include "ir_pulse_width_capture_defines.svh"

module irpw_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [irpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             acc,
  input  irpw_pkg::in_item_t               item,
  output irpw_pkg::ram_req_t               ram_req,
  output irpw_pkg::stage_info_t            info
);

  logic [irpw_pkg::GLITCH_W-1:0] glitch_r, glitch_nxt;
  logic [irpw_pkg::TMO_W-1:0]    timeout_r, timeout_nxt;
  logic [irpw_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [irpw_pkg::TIME_W-1:0]   last_r, last_nxt;
  logic                          done_r, done_nxt;
  logic [irpw_pkg::TIME_W-1:0]   gap;
  logic                          hit;

  always_comb begin
    glitch_nxt  = glitch_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      case (cfg_index)
        irpw_pkg::CFG_GLITCH_MIN:   glitch_nxt  = cfg_wdata[irpw_pkg::GLITCH_W-1:0];
        irpw_pkg::CFG_IDLE_TIMEOUT: timeout_nxt = cfg_wdata[irpw_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Gaps wrap modulo 2^32 like the timestamp itself.
  assign gap = item.time_us - last_r;

  always_comb begin
    count_nxt = count_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    hit       = 1'b0;
    ram_req   = '0;
    ram_req.waddr = count_r[irpw_pkg::IDX_W-1:0];
    ram_req.wdata = gap[irpw_pkg::WIDTH_W-1:0];
    ram_req.raddr = irpw_pkg::IDX_W'(item.read_index);
    if (acc) begin
      case (item.mode)
        irpw_pkg::MODE_EDGE: begin
          if (done_r) begin
            last_nxt = item.time_us;
          end else if (gap >= irpw_pkg::TIME_W'(glitch_r)) begin
            last_nxt = item.time_us;
            if (count_r < irpw_pkg::CNT_W'(irpw_pkg::CAPACITY)) begin
              ram_req.we = 1'b1;
              count_nxt  = count_r + 1'b1;
            end
          end
        end
        irpw_pkg::MODE_POLL: begin
          if (count_r != '0 && !done_r && gap > irpw_pkg::TIME_W'(timeout_r)) begin
            done_nxt = 1'b1;
          end
        end
        irpw_pkg::MODE_READ: begin
          // Only entries below the count were written in this frame.
          hit = irpw_pkg::CMP_W'(item.read_index) < irpw_pkg::CMP_W'(count_r);
          ram_req.re = hit;
        end
        default: begin
          count_nxt = '0;
          done_nxt  = 1'b0;
          last_nxt  = item.time_us;
        end
      endcase
    end
  end

  assign info.frame_ready = done_nxt;
  assign info.pulse_count = 7'(count_nxt);
  assign info.hit         = hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_r  <= irpw_pkg::GLITCH_RESET;
      timeout_r <= irpw_pkg::TIMEOUT_RESET;
      count_r   <= '0;
      last_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      glitch_r  <= glitch_nxt;
      timeout_r <= timeout_nxt;
      count_r   <= count_nxt;
      last_r    <= last_nxt;
      done_r    <= done_nxt;
    end
  end

  `IRPW_ASSERT_IMP(a_done_needs_count, done_r, count_r != '0, "frame complete with no widths")
  `IRPW_ASSERT_IMP(a_count_bound, 1'b1, count_r <= irpw_pkg::CNT_W'(irpw_pkg::CAPACITY), "count past capacity")
  `IRPW_ASSERT_NXT(a_clear_frame, acc && item.mode == irpw_pkg::MODE_CLEAR, count_r == '0 && !done_r, "frame reset did not clear state")
  `IRPW_ASSERT_IMP(a_no_write_when_done, ram_req.we, !done_r && acc && item.mode == irpw_pkg::MODE_EDGE, "width stored outside an open-frame edge")

endmodule

// ===== rtl/ir_pulse_width_capture.sv =====
// Infrared pulse width capture: one result item for every input item.
// A result passes through the read stage and then the output register before it is offered.
// Throughput: one item per cycle while out_stall is low, bounded by the width store's single write and read port.
// A two-entry pipeline (read stage plus output register) absorbs output stalls without a bubble.
// Reset (synchronous, rst_n low) clears the frame state, the pipeline valids and the registers to
// their defaults; the width store is not cleared and needs no clearing pass.
`include "ir_pulse_width_capture_defines.svh"

module ir_pulse_width_capture (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [irpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  irpw_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output irpw_pkg::out_item_t             out_data
);

  irpw_pkg::ram_req_t    ram_req;
  irpw_pkg::stage_info_t info;
  irpw_pkg::stage_info_t s1_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  irpw_pkg::out_item_t   out_data_r;
  logic [irpw_pkg::WIDTH_W-1:0] rdata;
  logic                  out_free;
  logic                  in_acc;

  // The output register can take a new item when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  // Stall only when the read stage holds an item that cannot move on.
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Frame state lives in the control unit and is updated at acceptance.
  irpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (in_acc),
    .item      (in_data),
    .ram_req   (ram_req),
    .info      (info)
  );

  // Edges and reads never share a cycle, and a read of an entry written in the
  // previous cycle sees the new data, so no forwarding path is required.
  irpw_ram #(
    .WIDTH (irpw_pkg::WIDTH_W),
    .DEPTH (irpw_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // The read data holds while the read stage waits, since no new read is
  // issued until that stage drains.
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !out_free);
  assign out_valid_nxt = out_free ? s1_valid_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= info;
    end
    if (out_free && s1_valid_r) begin
      out_data_r.frame_ready <= s1_r.frame_ready;
      out_data_r.pulse_count <= s1_r.pulse_count;
      out_data_r.entry_width <= s1_r.hit ? rdata : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IRPW_ASSERT_IMP(a_stall_needs_stage, in_stall, s1_valid_r && out_valid_r, "input stalled with room in the pipeline")
  `IRPW_ASSERT_NXT(a_accept_fills_stage, in_acc, s1_valid_r, "accepted item did not enter the read stage")

endmodule
